// File: rtl/core/assert_macros.svh
// Assertion macros used by the I2C byte master sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I2CBM_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define I2CBM_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/i2cbm_pkg.sv
package i2cbm_pkg;

    localparam int CFG_W = 16;
    localparam logic [CFG_W-1:0] HALF_PERIOD_RST = 16'd3;

    // Command codes carried on the input tuser.
    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_START = 3'd1;
    localparam logic [2:0] REQ_STOP  = 3'd2;
    localparam logic [2:0] REQ_WRITE = 3'd3;
    localparam logic [2:0] REQ_READ  = 3'd4;
    localparam logic [2:0] REQ_CLEAR = 3'd5;

    // Bus sequencer phases.
    localparam logic [4:0] PH_IDLE    = 5'd0;
    localparam logic [4:0] PH_FIN     = 5'd1;
    localparam logic [4:0] PH_ST_REL  = 5'd2;
    localparam logic [4:0] PH_ST_HI   = 5'd3;
    localparam logic [4:0] PH_ST_SDA  = 5'd4;
    localparam logic [4:0] PH_ST_SCL  = 5'd5;
    localparam logic [4:0] PH_SP_LOW  = 5'd6;
    localparam logic [4:0] PH_SP_REL  = 5'd7;
    localparam logic [4:0] PH_SP_HI   = 5'd8;
    localparam logic [4:0] PH_SP_SDA  = 5'd9;
    localparam logic [4:0] PH_WR_BIT  = 5'd10;
    localparam logic [4:0] PH_WR_REL  = 5'd11;
    localparam logic [4:0] PH_WR_HI   = 5'd12;
    localparam logic [4:0] PH_WR_LOW  = 5'd13;
    localparam logic [4:0] PH_WR_ASDA = 5'd14;
    localparam logic [4:0] PH_WR_AREL = 5'd15;
    localparam logic [4:0] PH_WR_AHI  = 5'd16;
    localparam logic [4:0] PH_WR_END  = 5'd17;
    localparam logic [4:0] PH_RD_INIT = 5'd18;
    localparam logic [4:0] PH_RD_REL  = 5'd19;
    localparam logic [4:0] PH_RD_HI   = 5'd20;
    localparam logic [4:0] PH_RD_LOW  = 5'd21;
    localparam logic [4:0] PH_RD_ASDA = 5'd22;
    localparam logic [4:0] PH_RD_AREL = 5'd23;
    localparam logic [4:0] PH_RD_AHI  = 5'd24;
    localparam logic [4:0] PH_RD_END  = 5'd25;
    localparam logic [4:0] PH_BC_SDA  = 5'd26;
    localparam logic [4:0] PH_BC_SCL  = 5'd27;
    localparam logic [4:0] PH_BC_REL  = 5'd28;
    localparam logic [4:0] PH_BC_HI   = 5'd29;
    localparam logic [4:0] PH_BC_END  = 5'd30;

    localparam logic [3:0] DATA_BITS  = 4'd8;
    localparam logic [3:0] CLEAR_PULSES = 4'd9;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] tx_byte;
        logic       msb_first;
        logic       last_byte;
        logic       scl_in;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_pull_low;
        logic       sda_pull_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       rejected;
    } result_t;

endpackage

// File: rtl/core/i2cbm_in_reg.sv
module i2cbm_in_reg
    import i2cbm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    input  logic  take,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    item_t item_reg;

    // A held beat is replaced in the same cycle that the sequencer consumes it.
    assign in_ready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// File: rtl/core/i2cbm_seq.sv
`include "assert_macros.svh"

module i2cbm_seq
    import i2cbm_pkg::*;
#(
    parameter int WAIT_WIDTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_en,
    input  item_t                 item,
    input  logic [WAIT_WIDTH-1:0] load_value,
    output result_t               res
);

    logic [4:0]            phase_reg, phase_next;
    logic [2:0]            oper_reg, oper_next;
    logic [3:0]            bit_cnt_reg, bit_cnt_next;
    logic [WAIT_WIDTH-1:0] wait_reg, wait_next;
    logic [7:0]            shift_reg, shift_next;
    logic                  order_msb_reg, order_msb_next;
    logic                  nack_last_reg, nack_last_next;
    logic                  scl_low_reg, scl_low_next;
    logic                  sda_low_reg, sda_low_next;

    logic       is_cmd;
    logic       do_adv;
    logic       done;
    logic       rejected;
    logic [7:0] rx_byte;

    assign is_cmd = (item.req_type >= REQ_START) && (item.req_type <= REQ_CLEAR);

    always_comb
    begin
        phase_next     = phase_reg;
        oper_next      = oper_reg;
        bit_cnt_next   = bit_cnt_reg;
        wait_next      = wait_reg;
        shift_next     = shift_reg;
        order_msb_next = order_msb_reg;
        nack_last_next = nack_last_reg;
        scl_low_next   = scl_low_reg;
        sda_low_next   = sda_low_reg;
        done           = 1'b0;
        rejected       = 1'b0;
        rx_byte        = 8'd0;
        do_adv         = 1'b1;

        // Command setup (rejected if busy); a write waits instead of a bus action.
        if (is_cmd && (phase_reg != PH_IDLE))
        begin
            rejected = 1'b1;
        end
        else if (is_cmd)
        begin
            oper_next      = item.req_type;
            bit_cnt_next   = 4'd0;
            wait_next      = '0;
            order_msb_next = item.msb_first;
            case (item.req_type)
                REQ_START: phase_next = PH_ST_REL;
                REQ_STOP:  phase_next = PH_SP_LOW;
                REQ_WRITE:
                begin
                    shift_next = item.tx_byte;
                    phase_next = PH_WR_BIT;
                    wait_next  = load_value;
                    do_adv     = 1'b0;
                end
                REQ_READ:
                begin
                    shift_next     = 8'd0;
                    nack_last_next = item.last_byte;
                    phase_next     = PH_RD_INIT;
                end
                default:   phase_next = PH_BC_SDA;
            endcase
        end

        if (do_adv && (phase_next != PH_IDLE))
        begin
            if (wait_next != '0)
            begin
                wait_next = wait_next - 1'b1;
            end
            else
            begin
                unique case (phase_next)
                    PH_FIN:
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    PH_ST_REL:
                    begin
                        scl_low_next = 1'b0;
                        sda_low_next = 1'b0;
                        phase_next   = PH_ST_HI;
                    end
                    PH_ST_HI:
                    begin
                        if (item.scl_in)
                        begin
                            phase_next = PH_ST_SDA;
                            wait_next  = load_value;
                        end
                    end
                    PH_ST_SDA:
                    begin
                        sda_low_next = 1'b1;
                        phase_next   = PH_ST_SCL;
                        wait_next    = load_value;
                    end
                    PH_ST_SCL:
                    begin
                        scl_low_next = 1'b1;
                        phase_next   = PH_IDLE;
                        done         = 1'b1;
                    end
                    PH_SP_LOW:
                    begin
                        scl_low_next = 1'b1;
                        sda_low_next = 1'b1;
                        phase_next   = PH_SP_REL;
                        wait_next    = load_value;
                    end
                    PH_SP_REL:
                    begin
                        scl_low_next = 1'b0;
                        phase_next   = PH_SP_HI;
                    end
                    PH_SP_HI:
                    begin
                        if (item.scl_in)
                        begin
                            phase_next = PH_SP_SDA;
                            wait_next  = load_value;
                        end
                    end
                    PH_SP_SDA:
                    begin
                        sda_low_next = 1'b0;
                        phase_next   = PH_FIN;
                        wait_next    = load_value;
                    end
                    PH_WR_BIT:
                    begin
                        if (order_msb_next)
                        begin
                            sda_low_next = !shift_next[7];
                            shift_next   = {shift_next[6:0], 1'b0};
                        end
                        else
                        begin
                            sda_low_next = !shift_next[0];
                            shift_next   = {1'b0, shift_next[7:1]};
                        end
                        phase_next = PH_WR_REL;
                        wait_next  = load_value;
                    end
                    PH_WR_REL:
                    begin
                        scl_low_next = 1'b0;
                        phase_next   = PH_WR_HI;
                    end
                    PH_WR_HI:
                    begin
                        if (item.scl_in)
                        begin
                            phase_next = PH_WR_LOW;
                            wait_next  = load_value;
                        end
                    end
                    PH_WR_LOW:
                    begin
                        scl_low_next = 1'b1;
                        bit_cnt_next = bit_cnt_next + 1'b1;
                        phase_next   = (bit_cnt_next >= DATA_BITS) ? PH_WR_ASDA : PH_WR_BIT;
                    end
                    PH_WR_ASDA:
                    begin
                        sda_low_next = 1'b0;
                        phase_next   = PH_WR_AREL;
                        wait_next    = load_value;
                    end
                    PH_WR_AREL:
                    begin
                        scl_low_next = 1'b0;
                        phase_next   = PH_WR_AHI;
                    end
                    PH_WR_AHI:
                    begin
                        if (item.scl_in)
                        begin
                            phase_next = PH_WR_END;
                            wait_next  = load_value;
                        end
                    end
                    PH_WR_END:
                    begin
                        scl_low_next = 1'b1;
                        sda_low_next = 1'b1;
                        phase_next   = PH_IDLE;
                        done         = 1'b1;
                    end
                    PH_RD_INIT:
                    begin
                        sda_low_next = 1'b0;
                        phase_next   = PH_RD_REL;
                        wait_next    = load_value;
                    end
                    PH_RD_REL:
                    begin
                        scl_low_next = 1'b0;
                        phase_next   = PH_RD_HI;
                    end
                    PH_RD_HI:
                    begin
                        // Data is taken on the tick that first sees SCL high.
                        if (item.scl_in)
                        begin
                            if (order_msb_next)
                            begin
                                shift_next = {shift_next[6:0], item.sda_in};
                            end
                            else
                            begin
                                shift_next = {item.sda_in, shift_next[7:1]};
                            end
                            phase_next = PH_RD_LOW;
                            wait_next  = load_value;
                        end
                    end
                    PH_RD_LOW:
                    begin
                        scl_low_next = 1'b1;
                        bit_cnt_next = bit_cnt_next + 1'b1;
                        phase_next   = (bit_cnt_next >= DATA_BITS) ? PH_RD_ASDA : PH_RD_REL;
                        wait_next    = load_value;
                    end
                    PH_RD_ASDA:
                    begin
                        sda_low_next = !nack_last_next;
                        phase_next   = PH_RD_AREL;
                        wait_next    = load_value;
                    end
                    PH_RD_AREL:
                    begin
                        scl_low_next = 1'b0;
                        phase_next   = PH_RD_AHI;
                    end
                    PH_RD_AHI:
                    begin
                        if (item.scl_in)
                        begin
                            phase_next = PH_RD_END;
                            wait_next  = load_value;
                        end
                    end
                    PH_RD_END:
                    begin
                        scl_low_next = 1'b1;
                        phase_next   = PH_IDLE;
                        done         = 1'b1;
                    end
                    PH_BC_SDA:
                    begin
                        sda_low_next = 1'b1;
                        phase_next   = PH_BC_SCL;
                        wait_next    = load_value;
                    end
                    PH_BC_SCL:
                    begin
                        scl_low_next = 1'b1;
                        phase_next   = PH_BC_REL;
                        wait_next    = load_value;
                    end
                    PH_BC_REL:
                    begin
                        scl_low_next = 1'b0;
                        phase_next   = PH_BC_HI;
                    end
                    PH_BC_HI:
                    begin
                        if (item.scl_in)
                        begin
                            phase_next = PH_BC_END;
                            wait_next  = load_value;
                        end
                    end
                    PH_BC_END:
                    begin
                        sda_low_next = 1'b0;
                        bit_cnt_next = bit_cnt_next + 1'b1;
                        phase_next   = (bit_cnt_next >= CLEAR_PULSES) ? PH_FIN : PH_BC_SDA;
                        wait_next    = load_value;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        wait_next  = '0;
                    end
                endcase
            end
        end

        if (done)
        begin
            wait_next = '0;
            rx_byte   = (oper_next == REQ_READ) ? shift_next : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            oper_reg      <= REQ_TICK;
            bit_cnt_reg   <= 4'd0;
            wait_reg      <= '0;
            shift_reg     <= 8'd0;
            order_msb_reg <= 1'b1;
            nack_last_reg <= 1'b0;
            scl_low_reg   <= 1'b0;
            sda_low_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg     <= phase_next;
            oper_reg      <= oper_next;
            bit_cnt_reg   <= bit_cnt_next;
            wait_reg      <= wait_next;
            shift_reg     <= shift_next;
            order_msb_reg <= order_msb_next;
            nack_last_reg <= nack_last_next;
            scl_low_reg   <= scl_low_next;
            sda_low_reg   <= sda_low_next;
        end
    end

    always_comb
    begin
        res.scl_pull_low = scl_low_next;
        res.sda_pull_low = sda_low_next;
        res.busy_res     = (phase_next != PH_IDLE);
        res.done_res     = done;
        res.rx_byte      = rx_byte;
        res.rejected     = rejected;
    end

    `I2CBM_ASSERT_NXT(a_done_leaves_idle, clk, rst_n, step_en && done, phase_reg == PH_IDLE, "completed command did not return to idle")
    `I2CBM_ASSERT_IMP(a_reject_only_busy, clk, rst_n, step_en && rejected, phase_reg != PH_IDLE, "command rejected while idle")
    `I2CBM_ASSERT_IMP(a_wait_only_busy, clk, rst_n, wait_reg != '0, phase_reg != PH_IDLE, "wait count running while idle")
    `I2CBM_ASSERT_NXT(a_hold_without_beat, clk, rst_n, !step_en, $stable(phase_reg) && $stable(wait_reg), "sequencer moved without a beat")

endmodule

// File: rtl/core/i2c_bitbang_byte_master.sv
// A result beat is formed from its input beat by the input register, then one sequencer
// step into the result register; a result that is not taken holds the step back.
// Throughput: one beat per cycle while m_axis_tready does not stall the result register;
// the whole bus-phase step is combinational logic. Reset (rst_n, asynchronous, active low)
// idles the sequencer, releases SCL and SDA, empties both registers and sets half_period_ticks to 3.
module i2c_bitbang_byte_master
    import i2cbm_pkg::*;
#(
    parameter int WAIT_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,       // half_period_ticks
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // tx_byte[7:0], msb_first, scl_in, sda_in, zero pad
    input  logic [2:0]  s_axis_tuser,   // req_type
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // scl_pull_low, sda_pull_low, busy_res, done_res,
                                        // rx_byte[7:0], rejected, zero pad
);

    localparam int CW = (WAIT_WIDTH > CFG_W) ? WAIT_WIDTH : CFG_W;
    localparam logic [CW-1:0] WAIT_MAX = CW'({WAIT_WIDTH{1'b1}});

    logic [CFG_W-1:0]      half_reg;
    logic [CW-1:0]         half_ext;
    logic [WAIT_WIDTH-1:0] load_value;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    out_free;
    logic    step_en;
    result_t res;

    logic        m_valid_reg;
    logic [15:0] m_data_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= HALF_PERIOD_RST;
        end
        else if (cfg_valid)
        begin
            half_reg <= cfg_data;
        end
    end

    // Zero acts as one; values beyond the counter range saturate.
    assign half_ext   = CW'(half_reg);
    assign load_value = (half_reg == '0)     ? WAIT_WIDTH'(1) :
                        (half_ext > WAIT_MAX) ? WAIT_MAX[WAIT_WIDTH-1:0] :
                                                half_ext[WAIT_WIDTH-1:0];

    assign in_item.req_type  = s_axis_tuser;
    assign in_item.tx_byte   = s_axis_tdata[7:0];
    assign in_item.msb_first = s_axis_tdata[8];
    assign in_item.last_byte = s_axis_tlast;
    assign in_item.scl_in    = s_axis_tdata[9];
    assign in_item.sda_in    = s_axis_tdata[10];

    assign out_free = !m_valid_reg || m_axis_tready;
    assign step_en  = item_valid && out_free;

    i2cbm_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .take       (step_en),
        .item_valid (item_valid),
        .item       (item)
    );

    i2cbm_seq #(
        .WAIT_WIDTH (WAIT_WIDTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (step_en),
        .item       (item),
        .load_value (load_value),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (step_en)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            m_data_reg <= {3'b000, res.rejected, res.rx_byte, res.done_res, res.busy_res,
                           res.sda_pull_low, res.scl_pull_low};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule
